/* hdl/pcev_pkg.sv */
// Shared definitions for the parametric curve evaluator: mode codes,
// parameter defaults, multiplier limb width and per-stage load-enable bundles.
// No dependencies.
package pcev_pkg;

  localparam int COORD_BITS_DFLT  = 32;
  localparam int U_FRAC_BITS_DFLT = 16;

  // weight slice width fed to each coordinate multiplier
  localparam int LIMB_W = 24;

  typedef enum logic [2:0] {
    MODE_QUAD    = 3'd0,
    MODE_QUAD_D  = 3'd1,
    MODE_CUBIC   = 3'd2,
    MODE_CUBIC_D = 3'd3,
    MODE_HERM    = 3'd4,
    MODE_HERM_D  = 3'd5
  } mode_t;

  // load enables of the weight generator stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } wgt_en_t;

  // load enables of the multiply/accumulate/finish stages
  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
    logic s8;
    logic s9;
  } mac_en_t;

endpackage

/* hdl/pcev_weight.sv */
// Basis weight generator, pipeline stages 1 to 4: clamps u, forms the
// powers of u and (1-u), then the four mode weights scaled to 3F fraction bits.
// Depends on pcev_pkg.
module pcev_weight #(
  parameter int U_FRAC_BITS = pcev_pkg::U_FRAC_BITS_DFLT
) (
  input  logic                       clk,
  input  pcev_pkg::wgt_en_t          en,
  input  logic [2:0]                 mode,
  input  logic [U_FRAC_BITS:0]       param_u,
  output logic [4*(3*U_FRAC_BITS+3)-1:0] weights
);
  import pcev_pkg::*;

  localparam int F  = U_FRAC_BITS;
  localparam int UW = F + 1;
  localparam int W  = 3 * F + 3;
  localparam int IW = 3 * F + 6;

  localparam logic [UW-1:0] U_ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [IW-1:0] O2 = {{(IW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [IW-1:0] O3 = {{(IW-3*F-1){1'b0}}, 1'b1, {(3*F){1'b0}}};

  function automatic logic signed [IW-1:0] x3(input logic signed [IW-1:0] x);
    return (x <<< 1) + x;
  endfunction

  // stage 1
  logic [2:0]        s1_mode_r;
  logic [UW-1:0]     s1_t_r, s1_v_r;
  logic [UW-1:0]     u_clamp;
  // stage 2
  logic [2:0]        s2_mode_r;
  logic [UW-1:0]     s2_t_r, s2_v_r;
  logic [2*UW-1:0]   s2_tt_r, s2_vv_r, s2_vt_r;
  // stage 3
  logic [2:0]        s3_mode_r;
  logic [UW-1:0]     s3_t_r, s3_v_r;
  logic [2*UW-1:0]   s3_tt_r, s3_vv_r, s3_vt_r;
  logic [3*UW-1:0]   s3_ttt_r, s3_vvv_r, s3_vvt_r, s3_vtt_r;
  // stage 4
  logic signed [IW-1:0] w_nxt [4];
  logic signed [W-1:0]  w_r   [4];

  assign u_clamp = (param_u > U_ONE) ? U_ONE : param_u;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_mode_r <= mode;
      s1_t_r    <= u_clamp;
      s1_v_r    <= U_ONE - u_clamp;
    end
    if (en.s2) begin
      s2_mode_r <= s1_mode_r;
      s2_t_r    <= s1_t_r;
      s2_v_r    <= s1_v_r;
      s2_tt_r   <= s1_t_r * s1_t_r;
      s2_vv_r   <= s1_v_r * s1_v_r;
      s2_vt_r   <= s1_v_r * s1_t_r;
    end
    if (en.s3) begin
      s3_mode_r <= s2_mode_r;
      s3_t_r    <= s2_t_r;
      s3_v_r    <= s2_v_r;
      s3_tt_r   <= s2_tt_r;
      s3_vv_r   <= s2_vv_r;
      s3_vt_r   <= s2_vt_r;
      s3_ttt_r  <= s2_tt_r * s2_t_r;
      s3_vvv_r  <= s2_vv_r * s2_v_r;
      s3_vvt_r  <= s2_vv_r * s2_t_r;
      s3_vtt_r  <= s2_tt_r * s2_v_r;
    end
    if (en.s4) begin
      for (int i = 0; i < 4; i++) begin
        w_r[i] <= w_nxt[i][W-1:0];
      end
    end
  end

  // weights, every mode brought to 3F fraction bits
  always_comb begin
    logic signed [IW-1:0] t, v, tt, vv, vt, ttt, vvv, vvt, vtt, ot, ot2, o2t;
    t   = $signed(IW'(s3_t_r));
    v   = $signed(IW'(s3_v_r));
    tt  = $signed(IW'(s3_tt_r));
    vv  = $signed(IW'(s3_vv_r));
    vt  = $signed(IW'(s3_vt_r));
    ttt = $signed(IW'(s3_ttt_r));
    vvv = $signed(IW'(s3_vvv_r));
    vvt = $signed(IW'(s3_vvt_r));
    vtt = $signed(IW'(s3_vtt_r));
    ot  = t <<< F;
    ot2 = tt <<< F;
    o2t = t <<< (2 * F);
    unique case (mode_t'(s3_mode_r))
      MODE_QUAD: begin
        w_nxt[0] = vv <<< F;
        w_nxt[1] = vt <<< (F + 1);
        w_nxt[2] = tt <<< F;
        w_nxt[3] = '0;
      end
      MODE_QUAD_D: begin
        w_nxt[0] = -(v <<< (2 * F + 1));
        w_nxt[1] = (v - t) <<< (2 * F + 1);
        w_nxt[2] = t <<< (2 * F + 1);
        w_nxt[3] = '0;
      end
      MODE_CUBIC: begin
        w_nxt[0] = vvv;
        w_nxt[1] = x3(vvt);
        w_nxt[2] = x3(vtt);
        w_nxt[3] = ttt;
      end
      MODE_CUBIC_D: begin
        w_nxt[0] = -(x3(vv) <<< F);
        w_nxt[1] = x3(O2 - (ot <<< 2) + x3(tt)) <<< F;
        w_nxt[2] = x3((ot <<< 1) - x3(tt)) <<< F;
        w_nxt[3] = x3(tt) <<< F;
      end
      MODE_HERM: begin
        w_nxt[0] = (ttt <<< 1) - x3(ot2) + O3;
        w_nxt[1] = ttt - (ot2 <<< 1) + o2t;
        w_nxt[2] = x3(ot2) - (ttt <<< 1);
        w_nxt[3] = ttt - ot2;
      end
      MODE_HERM_D: begin
        w_nxt[0] = x3(tt - ot) <<< (F + 1);
        w_nxt[1] = (x3(tt) - (ot <<< 2) + O2) <<< F;
        w_nxt[2] = x3(ot - tt) <<< (F + 1);
        w_nxt[3] = (x3(tt) - (ot <<< 1)) <<< F;
      end
      default: begin
        // undefined modes: zero weights give a zero, unclamped result
        for (int i = 0; i < 4; i++) begin
          w_nxt[i] = '0;
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      weights[i*W +: W] = w_r[i];
    end
  end

endmodule

/* hdl/pcev_mac.sv */
// One coordinate axis, pipeline stages 5 to 9: sliced weight-by-coordinate
// products, registered adder tree, round to nearest and saturate.
// Depends on pcev_pkg.
module pcev_mac #(
  parameter int COORD_BITS  = pcev_pkg::COORD_BITS_DFLT,
  parameter int U_FRAC_BITS = pcev_pkg::U_FRAC_BITS_DFLT
) (
  input  logic                            clk,
  input  pcev_pkg::mac_en_t               en,
  input  logic [4*(3*U_FRAC_BITS+3)-1:0]  weights,
  input  logic [4*COORD_BITS-1:0]         coords,
  output logic signed [COORD_BITS-1:0]    result,
  output logic                            sat
);
  import pcev_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = U_FRAC_BITS;
  localparam int W  = 3 * F + 3;
  localparam int LW = LIMB_W;
  localparam int NL = (W + LW - 1) / LW;
  localparam int WX = NL * LW + 1;
  localparam int PW = LW + 1 + C;
  localparam int AW = W + C + 2;
  localparam int SH = 3 * F;
  localparam int RW = AW - SH;

  localparam logic signed [AW-1:0] HALF = {{(AW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
  localparam logic signed [RW-1:0] MAXV = {{(RW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = {{(RW-C+1){1'b1}}, {(C-1){1'b0}}};

  logic signed [PW-1:0] prod_nxt [4][NL];
  logic signed [PW-1:0] prod_r   [4][NL];
  logic signed [AW-1:0] term_nxt [4];
  logic signed [AW-1:0] term_r   [4];
  logic signed [AW-1:0] half_r   [2];
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] rnd;
  logic signed [RW-1:0] shifted;
  logic signed [C-1:0]  result_r, result_nxt;
  logic                 sat_r, sat_nxt;

  // stage 5: each weight cut into limbs, low limbs unsigned, top limb signed
  always_comb begin
    logic [WX-1:0]       wx;
    logic signed [LW:0]  limb;
    logic signed [C-1:0] cd;
    for (int i = 0; i < 4; i++) begin
      wx = {{(WX-W){weights[i*W+W-1]}}, weights[i*W +: W]};
      cd = coords[i*C +: C];
      for (int l = 0; l < NL; l++) begin
        limb = (l == NL - 1) ? wx[l*LW +: LW+1] : {1'b0, wx[l*LW +: LW]};
        prod_nxt[i][l] = limb * cd;
      end
    end
  end

  // stage 6: recombine limb products per weight
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term_nxt[i] = '0;
      for (int l = 0; l < NL; l++) begin
        term_nxt[i] = term_nxt[i] +
          ($signed({{(AW-PW){prod_r[i][l][PW-1]}}, prod_r[i][l]}) <<< (LW * l));
      end
    end
  end

  // stage 9: add half, drop fraction, clamp
  assign rnd     = acc_r + HALF;
  assign shifted = rnd[AW-1:SH];

  always_comb begin
    sat_nxt    = 1'b0;
    result_nxt = shifted[C-1:0];
    if (shifted > MAXV) begin
      sat_nxt    = 1'b1;
      result_nxt = MAXV[C-1:0];
    end else if (shifted < MINV) begin
      sat_nxt    = 1'b1;
      result_nxt = MINV[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      prod_r <= prod_nxt;
    end
    if (en.s6) begin
      term_r <= term_nxt;
    end
    if (en.s7) begin
      half_r[0] <= term_r[0] + term_r[1];
      half_r[1] <= term_r[2] + term_r[3];
    end
    if (en.s8) begin
      acc_r <= half_r[0] + half_r[1];
    end
    if (en.s9) begin
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign result = result_r;
  assign sat    = sat_r;

endmodule

/* hdl/parametric_curve_evaluator.sv */
// Top level of the parametric curve evaluator: stage valid bits, flow
// control, point delay line; instantiates pcev_weight and two pcev_mac.
// Depends on pcev_pkg, pcev_weight, pcev_mac.
//
// Usage:
//   Input channel (in_valid/in_ready): one transfer carries a mode, four
//   Q16.16 points and u in Q1.16. Modes: quadratic Bezier, cubic Bezier,
//   cubic Hermite (a, c endpoints; b, d tangents), each as position or
//   as derivative. u above 1.0 is treated as 1.0; modes 6 and 7 give 0.
//   Output channel (out_valid/out_ready): x, y and a flag that is set
//   when either coordinate was clamped to the coordinate range.
//   Throughput: one item per cycle, sustained while out_ready is high.
//   Nine register stages: u powers (3), weights (1), limb products (1),
//   adder tree (3) and round/saturate into the output register (1).
//   Each stage has its own valid bit and loads whenever it is empty or
//   the stage after it loads, so bubbles are squeezed out and in_ready
//   stays high while any stage is free, even with a result waiting.
//   When the receiver stalls, items pile up in the stages and nothing
//   is dropped or repeated; in_ready falls once all nine are full.
//   Reset (rst_n low, synchronous) empties every stage; data registers
//   keep stale contents that are never presented.
module parametric_curve_evaluator #(
  parameter int COORD_BITS  = pcev_pkg::COORD_BITS_DFLT,
  parameter int U_FRAC_BITS = pcev_pkg::U_FRAC_BITS_DFLT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_mode,
  input  logic signed [COORD_BITS-1:0] in_point_a_x,
  input  logic signed [COORD_BITS-1:0] in_point_a_y,
  input  logic signed [COORD_BITS-1:0] in_point_b_x,
  input  logic signed [COORD_BITS-1:0] in_point_b_y,
  input  logic signed [COORD_BITS-1:0] in_point_c_x,
  input  logic signed [COORD_BITS-1:0] in_point_c_y,
  input  logic signed [COORD_BITS-1:0] in_point_d_x,
  input  logic signed [COORD_BITS-1:0] in_point_d_y,
  input  logic [U_FRAC_BITS:0]         in_param_u,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_result_x,
  output logic signed [COORD_BITS-1:0] out_result_y,
  output logic                         out_saturated
);
  import pcev_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int W      = 3 * U_FRAC_BITS + 3;
  localparam int NSTAGE = 9;

  logic [NSTAGE:1]   vld_r, vld_nxt;
  logic [NSTAGE+1:1] load;       // load[k]: stage k takes its input this cycle
  logic [8*C-1:0]    pts_in;
  logic [8*C-1:0]    pts_r [4];  // points ride along stages 1..4
  wgt_en_t           wgt_en;
  mac_en_t           mac_en;
  logic [4*W-1:0]    weights;
  logic [4*C-1:0]    coords_x, coords_y;
  logic              sat_x, sat_y;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[NSTAGE+1] = out_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (load[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // slot 2*point+axis, point a first, x before y
  assign pts_in = {in_point_d_y, in_point_d_x, in_point_c_y, in_point_c_x,
                   in_point_b_y, in_point_b_x, in_point_a_y, in_point_a_x};

  always_ff @(posedge clk) begin
    if (load[1]) begin
      pts_r[0] <= pts_in;
    end
    for (int k = 1; k < 4; k++) begin
      if (load[k+1]) begin
        pts_r[k] <= pts_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      coords_x[i*C +: C] = pts_r[3][(2*i)*C +: C];
      coords_y[i*C +: C] = pts_r[3][(2*i+1)*C +: C];
    end
  end

  assign wgt_en = '{s1: load[1], s2: load[2], s3: load[3], s4: load[4]};
  assign mac_en = '{s5: load[5], s6: load[6], s7: load[7], s8: load[8], s9: load[9]};

  pcev_weight #(
    .U_FRAC_BITS(U_FRAC_BITS)
  ) u_weight (
    .clk    (clk),
    .en     (wgt_en),
    .mode   (in_mode),
    .param_u(in_param_u),
    .weights(weights)
  );

  pcev_mac #(
    .COORD_BITS (COORD_BITS),
    .U_FRAC_BITS(U_FRAC_BITS)
  ) u_mac_x (
    .clk    (clk),
    .en     (mac_en),
    .weights(weights),
    .coords (coords_x),
    .result (out_result_x),
    .sat    (sat_x)
  );

  pcev_mac #(
    .COORD_BITS (COORD_BITS),
    .U_FRAC_BITS(U_FRAC_BITS)
  ) u_mac_y (
    .clk    (clk),
    .en     (mac_en),
    .weights(weights),
    .coords (coords_y),
    .result (out_result_y),
    .sat    (sat_y)
  );

  assign in_ready      = load[1];
  assign out_valid     = vld_r[NSTAGE];
  assign out_saturated = sat_x | sat_y;

endmodule

/* tb/tb_parametric_curve_evaluator.sv */
// Self-checking testbench for parametric_curve_evaluator: directed corners, backpressure,
// and random items under three idling profiles, checked against an exact integer predictor.
// Depends on pcev_pkg and the parametric_curve_evaluator RTL.
module tb_parametric_curve_evaluator;
  import pcev_pkg::*;

  localparam int CB = COORD_BITS_DFLT;
  localparam int UF = U_FRAC_BITS_DFLT;
  localparam int UW = UF + 1;
  localparam int ONE_U = 1 << UF;
  localparam int U_ALL = (1 << (UF + 1)) - 1;
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  // 9 pipeline stages; a little slack on top for drains
  localparam int SETTLE = 20;
  // receiver hold-off long enough to fill all stages and then some
  localparam int HOLD_CYCLES = 60;
  // cycles with no transfer on either channel before the run is abandoned;
  // far beyond the hold-off plus any plausible random stall run
  localparam int WATCHDOG_LIMIT = 2000;

  // point order: a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  typedef struct {
    logic [2:0]             mode;
    logic signed [CB-1:0]   pt [8];
    logic [UF:0]            u;
  } curve_item_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 sat;
  } curve_point_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_mode = '0;
  logic signed [CB-1:0] in_point_a_x = '0;
  logic signed [CB-1:0] in_point_a_y = '0;
  logic signed [CB-1:0] in_point_b_x = '0;
  logic signed [CB-1:0] in_point_b_y = '0;
  logic signed [CB-1:0] in_point_c_x = '0;
  logic signed [CB-1:0] in_point_c_y = '0;
  logic signed [CB-1:0] in_point_d_x = '0;
  logic signed [CB-1:0] in_point_d_y = '0;
  logic [UF:0]          in_param_u = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CB-1:0] out_result_x;
  logic signed [CB-1:0] out_result_y;
  logic                 out_saturated;

  // expected curve points, oldest first
  curve_point_t pending_points [$];
  int mismatch_count = 0;
  int idle_cycles = 0;

  // idling profile, percent of cycles each side sits out
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // hold-off handshake: test side bumps requests, receiver serves them
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  parametric_curve_evaluator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_point_a_x  (in_point_a_x),
    .in_point_a_y  (in_point_a_y),
    .in_point_b_x  (in_point_b_x),
    .in_point_b_y  (in_point_b_y),
    .in_point_c_x  (in_point_c_x),
    .in_point_c_y  (in_point_c_y),
    .in_point_d_x  (in_point_d_x),
    .in_point_d_y  (in_point_d_y),
    .in_param_u    (in_param_u),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_x  (out_result_x),
    .out_result_y  (out_result_y),
    .out_saturated (out_saturated)
  );

  always #1 clk = ~clk;

  // Exact curve evaluation. Weights are integer polynomials in U with
  // O = 2^UF standing for 1.0, so the weighted sum carries 1, 2 or 3
  // multiples of UF extra fraction bits. 128 bits hold the worst case
  // (about 2^80) with room to spare.
  function automatic curve_point_t eval_curve(curve_item_t it);
    logic signed [127:0] t, o, v, acc, c, half, hi, lo;
    logic signed [127:0] w [4];
    int sh;
    curve_point_t r;
    r.x = '0;
    r.y = '0;
    r.sat = 1'b0;
    // u above one is treated as one
    t = (it.u > ONE_U) ? 128'(ONE_U) : 128'(it.u);
    o = 128'(ONE_U);
    v = o - t;
    w[3] = 0;
    case (it.mode)
      MODE_QUAD: begin
        w[0] = v * v;
        w[1] = 2 * v * t;
        w[2] = t * t;
        sh = 2 * UF;
      end
      MODE_QUAD_D: begin
        w[0] = -2 * v;
        w[1] = 2 * (v - t);
        w[2] = 2 * t;
        sh = UF;
      end
      MODE_CUBIC: begin
        w[0] = v * v * v;
        w[1] = 3 * v * v * t;
        w[2] = 3 * v * t * t;
        w[3] = t * t * t;
        sh = 3 * UF;
      end
      MODE_CUBIC_D: begin
        w[0] = -3 * v * v;
        w[1] = 3 * (o * o - 4 * o * t + 3 * t * t);
        w[2] = 3 * (2 * o * t - 3 * t * t);
        w[3] = 3 * t * t;
        sh = 2 * UF;
      end
      MODE_HERM: begin
        w[0] = 2 * t * t * t - 3 * o * t * t + o * o * o;
        w[1] = t * t * t - 2 * o * t * t + o * o * t;
        w[2] = 3 * o * t * t - 2 * t * t * t;
        w[3] = t * t * t - o * t * t;
        sh = 3 * UF;
      end
      MODE_HERM_D: begin
        w[0] = 6 * (t * t - o * t);
        w[1] = 3 * t * t - 4 * o * t + o * o;
        w[2] = 6 * (o * t - t * t);
        w[3] = 3 * t * t - 2 * o * t;
        sh = 2 * UF;
      end
      default: return r;   // undefined modes: zero point, no flag
    endcase
    half = 128'sd1 <<< (sh - 1);
    hi = (128'sd1 <<< (CB - 1)) - 1;
    lo = -(128'sd1 <<< (CB - 1));
    for (int ax = 0; ax < 2; ax++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        c = 128'(it.pt[2 * i + ax]);
        acc = acc + w[i] * c;
      end
      // round half up, then clamp
      acc = (acc + half) >>> sh;
      if (acc > hi) begin
        acc = hi;
        r.sat = 1'b1;
      end else if (acc < lo) begin
        acc = lo;
        r.sat = 1'b1;
      end
      if (ax == 0) r.x = acc[CB-1:0];
      else r.y = acc[CB-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Transfer monitor: predict on every input transfer, check every
  // output transfer against the oldest prediction.
  always @(posedge clk) begin
    curve_item_t seen;
    curve_point_t exp_pt;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d sat=%0b",
                                    out_result_x, out_result_y, out_saturated));
        end else begin
          exp_pt = pending_points.pop_front();
          if (out_result_x !== exp_pt.x)
            report_mismatch($sformatf("result_x got %0d want %0d", out_result_x, exp_pt.x));
          if (out_result_y !== exp_pt.y)
            report_mismatch($sformatf("result_y got %0d want %0d", out_result_y, exp_pt.y));
          if (out_saturated !== exp_pt.sat)
            report_mismatch($sformatf("saturated got %0b want %0b", out_saturated,
                                      exp_pt.sat));
        end
      end
      if (in_valid && in_ready) begin
        seen.mode = in_mode;
        seen.pt[0] = in_point_a_x;
        seen.pt[1] = in_point_a_y;
        seen.pt[2] = in_point_b_x;
        seen.pt[3] = in_point_b_y;
        seen.pt[4] = in_point_c_x;
        seen.pt[5] = in_point_c_y;
        seen.pt[6] = in_point_d_x;
        seen.pt[7] = in_point_d_y;
        seen.u = in_param_u;
        pending_points.push_back(eval_curve(seen));
      end
    end
  end

  // Receiver: serves a pending hold-off first, otherwise stalls at the
  // current idling rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a hung pipeline stops all transfers
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transfer. Valid is only lowered for a gap, so back-to-back
  // items keep valid high without a same-step toggle.
  task automatic send_item(input curve_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= it.mode;
    in_point_a_x <= it.pt[0];
    in_point_a_y <= it.pt[1];
    in_point_b_x <= it.pt[2];
    in_point_b_y <= it.pt[3];
    in_point_c_x <= it.pt[4];
    in_point_c_y <= it.pt[5];
    in_point_d_x <= it.pt[6];
    in_point_d_y <= it.pt[7];
    in_param_u   <= it.u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender pause: stop offering and wait for every expected result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mix of full-range, near-zero and extreme coordinates
  function automatic logic signed [CB-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return $urandom;
    if (pick < 8) return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    if (pick == 8) return C_MAX;
    return C_MIN;
  endfunction

  function automatic curve_item_t rand_item();
    curve_item_t it;
    int unsigned pick;
    it.mode = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
    for (int i = 0; i < 8; i++) it.pt[i] = rand_coord();
    pick = $urandom_range(9);
    if (pick < 7) it.u = UW'($urandom_range(ONE_U, 0));
    else if (pick == 7) it.u = $urandom_range(1) ? UW'(ONE_U) : '0;
    else if (pick == 8) it.u = UW'($urandom_range(U_ALL, ONE_U + 1));   // above one
    else it.u = UW'($urandom_range(255));
    return it;
  endfunction

  // Every mode once with a spread of u values, then saturation corners,
  // all-max / all-min points, junk in the ignored point d, and zeros.
  task automatic test_directed();
    curve_item_t it;
    int u_pick [8];
    mode_t sat_modes [5];
    u_pick = '{0, ONE_U, U_ALL, 1, ONE_U / 2, ONE_U - 1, ONE_U + 1, 'h0AAAA};
    sat_modes = '{MODE_QUAD_D, MODE_CUBIC_D, MODE_HERM_D, MODE_HERM, MODE_CUBIC};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int m = 0; m < 8; m++) begin
      it.mode = 3'(m);
      it.u = UW'(u_pick[m]);
      for (int i = 0; i < 8; i++) it.pt[i] = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      send_item(it);
    end
    // alternating max/min points feed full-scale coordinates into each of these modes
    foreach (sat_modes[k]) begin
      it.mode = sat_modes[k];
      it.u = (k == 3) ? UW'(ONE_U / 3) : UW'(ONE_U / 2);
      for (int i = 0; i < 8; i++) it.pt[i] = ((i / 2) % 2 == 0) ? C_MAX : C_MIN;
      send_item(it);
    end
    it.mode = MODE_CUBIC;
    it.u = UW'(ONE_U / 3);
    for (int i = 0; i < 8; i++) it.pt[i] = C_MAX;
    send_item(it);
    it.mode = MODE_QUAD;
    it.u = UW'(ONE_U);
    for (int i = 0; i < 8; i++) it.pt[i] = C_MIN;
    send_item(it);
    // quadratic modes must ignore point d
    it.mode = MODE_QUAD;
    it.u = UW'(ONE_U / 4);
    for (int i = 0; i < 6; i++) it.pt[i] = rand_coord();
    it.pt[6] = C_MIN;
    it.pt[7] = C_MAX;
    send_item(it);
    it.mode = MODE_QUAD_D;
    it.pt[6] = C_MAX;
    it.pt[7] = C_MIN;
    send_item(it);
    it.mode = MODE_HERM_D;
    it.u = '0;
    for (int i = 0; i < 8; i++) it.pt[i] = '0;
    send_item(it);
    drain();
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // stages fill and in_ready has to drop.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    drain();
    @(negedge clk);
    hold_requests++;
    @(posedge clk);
    repeat (40) send_item(rand_item());
    drain();
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_item(rand_item());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(300, 9, 81);
    test_random(300, 81, 9);
    test_random(300, 0, 0);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pcev_pkg.sv
hdl/pcev_weight.sv
hdl/pcev_mac.sv
hdl/parametric_curve_evaluator.sv
tb/tb_parametric_curve_evaluator.sv
